[rtl/pdd_pkg.sv]
// Shared constants, types and the arctangent table of the point direction core.
package pdd_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int CORDIC_STAGES   = 18;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int MAX_STAGES  = 32;
    localparam int STAGES      = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int STAGE_IDX_W = $clog2(MAX_STAGES);

    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PATH_FRAC   = 16;
    // Vector magnitude grows by at most sqrt(2) * 1.65 in the rotation stages.
    localparam int PATH_W      = DIFF_W + 3 + PATH_FRAC;
    localparam int ACC_FRAC    = 24;
    localparam int ATAN_W      = 30;
    localparam int Z_W         = ACC_FRAC + 11;
    localparam int OUT_W       = 9 + ANGLE_FRAC_BITS;
    localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam int IN_TDATA_W  = ((4 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int DEG_QUARTER       = 90;
    localparam int DEG_HALF          = 180;
    localparam int DEG_THREE_QUARTER = 270;
    localparam int DEG_FULL          = 360;

    localparam logic [Z_W-1:0] Z_HALF = Z_W'(DEG_HALF) << ACC_FRAC;
    localparam logic [Z_W-1:0] Z_FULL = Z_W'(DEG_FULL) << ACC_FRAC;
    localparam logic [Z_W-1:0] Z_ROUND_HALF = Z_W'(1) << (ROUND_SHIFT - 1);

    localparam logic [OUT_W:0]   OUT_FULL    = (OUT_W + 1)'(DEG_FULL) << ANGLE_FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_UP      = OUT_W'(DEG_QUARTER) << ANGLE_FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_DOWN    = OUT_W'(DEG_THREE_QUARTER) << ANGLE_FRAC_BITS;

    typedef struct packed {
        logic                     vert;
        logic                     dy_neg;
        logic signed [PATH_W-1:0] x;
        logic signed [PATH_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } cell_data_t;

    // atan(2^-i) in degrees with 24 fraction bits, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STAGE_IDX_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:  v = ATAN_W'(754974720);
            5'd1:  v = ATAN_W'(445687602);
            5'd2:  v = ATAN_W'(235489089);
            5'd3:  v = ATAN_W'(119537938);
            5'd4:  v = ATAN_W'(60000934);
            5'd5:  v = ATAN_W'(30029717);
            5'd6:  v = ATAN_W'(15018523);
            5'd7:  v = ATAN_W'(7509720);
            5'd8:  v = ATAN_W'(3754917);
            5'd9:  v = ATAN_W'(1877466);
            5'd10: v = ATAN_W'(938734);
            5'd11: v = ATAN_W'(469367);
            5'd12: v = ATAN_W'(234684);
            5'd13: v = ATAN_W'(117342);
            5'd14: v = ATAN_W'(58671);
            5'd15: v = ATAN_W'(29335);
            5'd16: v = ATAN_W'(14668);
            5'd17: v = ATAN_W'(7334);
            5'd18: v = ATAN_W'(3667);
            5'd19: v = ATAN_W'(1833);
            5'd20: v = ATAN_W'(917);
            5'd21: v = ATAN_W'(458);
            5'd22: v = ATAN_W'(229);
            5'd23: v = ATAN_W'(115);
            5'd24: v = ATAN_W'(57);
            5'd25: v = ATAN_W'(29);
            5'd26: v = ATAN_W'(14);
            5'd27: v = ATAN_W'(7);
            5'd28: v = ATAN_W'(4);
            5'd29: v = ATAN_W'(2);
            5'd30: v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/pdd_prep.sv]
// Input stage: coordinate differences and the fold into the right half plane.
module pdd_prep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [pdd_pkg::IN_TDATA_W-1:0]     in_data,
    output logic                               out_valid,
    output pdd_pkg::cell_data_t                out_data
);
    import pdd_pkg::*;

    logic [COORD_WIDTH-1:0]   from_x;
    logic [COORD_WIDTH-1:0]   from_y;
    logic [COORD_WIDTH-1:0]   to_x;
    logic [COORD_WIDTH-1:0]   to_y;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] x_fold;
    logic signed [DIFF_W-1:0] y_fold;
    logic                     valid_reg;
    cell_data_t               data_reg;
    cell_data_t               data_next;

    assign from_x = in_data[COORD_WIDTH-1:0];
    assign from_y = in_data[2*COORD_WIDTH-1:COORD_WIDTH];
    assign to_x   = in_data[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign to_y   = in_data[4*COORD_WIDTH-1:3*COORD_WIDTH];

    assign dx = $signed({to_x[COORD_WIDTH-1], to_x}) - $signed({from_x[COORD_WIDTH-1], from_x});
    assign dy = $signed({to_y[COORD_WIDTH-1], to_y}) - $signed({from_y[COORD_WIDTH-1], from_y});

    // Screen y points down, so the upward component is -dy. A vector in the
    // left half plane is turned by a half turn and starts at 180 degrees.
    always_comb
    begin
        if (dx < 0)
        begin
            x_fold = -dx;
            y_fold = dy;
        end
        else
        begin
            x_fold = dx;
            y_fold = -dy;
        end
        data_next.vert   = (dx == '0);
        data_next.dy_neg = dy[DIFF_W-1];
        data_next.x      = PATH_W'(x_fold) <<< PATH_FRAC;
        data_next.y      = PATH_W'(y_fold) <<< PATH_FRAC;
        data_next.z      = (dx < 0) ? $signed(Z_HALF) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

[rtl/pdd_cell.sv]
// One vectoring rotation of the CORDIC chain.
module pdd_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [pdd_pkg::STAGE_IDX_W-1:0]   stage,
    input  logic                              in_valid,
    input  pdd_pkg::cell_data_t               in_data,
    output logic                              out_valid,
    output pdd_pkg::cell_data_t               out_data
);
    import pdd_pkg::*;

    logic signed [PATH_W-1:0] xs;
    logic signed [PATH_W-1:0] ys;
    logic signed [Z_W-1:0]    angle;
    logic                     valid_reg;
    cell_data_t               data_reg;
    cell_data_t               data_next;

    assign xs    = in_data.x >>> stage;
    assign ys    = in_data.y >>> stage;
    assign angle = $signed(Z_W'(atan_entry(stage)));

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb
    begin
        data_next        = in_data;
        if (in_data.y > 0)
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + angle;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

[rtl/pdd_round.sv]
// Final angle: wrap into one turn, then round to the output resolution.
module pdd_round (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  pdd_pkg::cell_data_t           in_data,
    output logic                          out_valid,
    output logic [pdd_pkg::OUT_W-1:0]     direction
);
    import pdd_pkg::*;

    logic                  valid_reg;
    logic                  vert_reg;
    logic                  dy_neg_reg;
    logic [Z_W-1:0]        total_reg;
    logic [Z_W-1:0]        total_next;
    logic [Z_W-1:0]        biased;
    logic [OUT_W:0]        rounded;
    logic [OUT_W:0]        wrapped;

    always_comb
    begin
        if (in_data.z < 0)
            total_next = $unsigned(in_data.z) + Z_FULL;
        else if ($unsigned(in_data.z) >= Z_FULL)
            total_next = $unsigned(in_data.z) - Z_FULL;
        else
            total_next = $unsigned(in_data.z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            total_reg  <= total_next;
            vert_reg   <= in_data.vert;
            dy_neg_reg <= in_data.dy_neg;
        end
    end

    assign biased  = total_reg + Z_ROUND_HALF;
    assign rounded = biased[ROUND_SHIFT +: (OUT_W + 1)];
    assign wrapped = (rounded >= OUT_FULL) ? (rounded - OUT_FULL) : rounded;

    // A vertical vector, including the zero vector, takes a fixed angle.
    always_comb
    begin
        if (vert_reg)
            direction = dy_neg_reg ? OUT_UP : OUT_DOWN;
        else
            direction = wrapped[OUT_W-1:0];
    end

    assign out_valid = valid_reg;
endmodule

[rtl/point_direction_degrees_core.sv]
// Top level of the point direction core: input stage, CORDIC chain, rounding and output.
// Computes the direction from a start point to a target point given in screen coordinates
// (y grows downward), as degrees counterclockwise from +x with 8 fraction bits, 0 to
// just under 360. One transaction is accepted every clock cycle while s_tready is high;
// it passes one input stage, 18 CORDIC rotation cells, one wrap stage and the output
// register. Back pressure stalls the whole chain; a skid register at the output keeps
// s_tready a registered signal, so it drops in the cycle after a result parks there.
module point_direction_degrees_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // from_x [15:0], from_y [31:16], to_x [47:32], to_y [63:48]
    input  logic [pdd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // direction [16:0], zero padding above
    output logic [pdd_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import pdd_pkg::*;

    logic              en;
    logic              chain_valid [0:STAGES];
    cell_data_t        chain_data  [0:STAGES];
    logic              res_valid;
    logic [OUT_W-1:0]  res_dir;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_dir_reg;
    logic              skid_valid_reg;
    logic [OUT_W-1:0]  skid_dir_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    pdd_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cell
        pdd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage     (STAGE_IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    pdd_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[STAGES]),
        .in_data   (chain_data[STAGES]),
        .out_valid (res_valid),
        .direction (res_dir)
    );

    // A result that arrives while the output register is stalled parks in the
    // skid register, which then holds the chain until it drains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && !m_tready)
        begin
            skid_valid_reg <= res_valid;
        end
        else
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_dir_reg <= skid_dir_reg;
        end
        else if (out_valid_reg && !m_tready)
        begin
            skid_dir_reg <= res_dir;
        end
        else
        begin
            out_dir_reg <= res_dir;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_dir_reg);
endmodule
